### sv/multi_channel_sample_ring_fifo_unit_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the multi-channel sample ring fifo
// concurrent checks on clk with a synchronous active-high rst
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SAMPLE_RING_FIFO_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_SAMPLE_RING_FIFO_UNIT_ASSERT_SVH

// same-cycle implication
`define MCSRF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCSRF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mcsrf_pkg.sv
// ----------------------------------------------------------------------------
// mcsrf_pkg
// shared constants and codes of the multi-channel sample ring fifo
// ----------------------------------------------------------------------------
package mcsrf_pkg;

  // default geometry
  localparam int CHANNELS_DEF   = 8;
  localparam int RING_DEPTH_DEF = 1024;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CHAN_W   = 3;
  localparam int PULL_W   = 7;

  // pull burst limit
  localparam logic [PULL_W-1:0] PULL_LIMIT_CAP = 7'd64;
  localparam logic [PULL_W-1:0] PULL_BURST_RST = 7'd64;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_PUSH_OK    = 2'd0,
    ST_PUSH_FULL  = 2'd1,
    ST_PULL_DATA  = 2'd2,
    ST_PULL_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_PULL
  } state_t;

endpackage

### sv/multi_channel_sample_ring_fifo_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_sample_ring_fifo_unit
// per-channel ring fifos of signed 16-bit samples in one shared memory
// ----------------------------------------------------------------------------
// usage
//   a request is taken at a rising edge with start high and busy low.
//   opcode push offers sample_in to the ring of channel; one result says
//   accepted or refused. once a burst hits a full ring the rest of the burst
//   is refused up to the sample marked burst_last.
//   opcode pull drains min(fill, lim) samples oldest first, lim being
//   max_pull_burst clamped to 1..64; one result per cycle, last marking
//   the final one; an empty ring gives one empty result. max_pull_burst
//   is written through cfg_wr_en / cfg_wr_data. results show for one cycle
//   with strobe high; the receiver cannot stall.
// order
//   push: the channel table is read at acceptance and the result is
//   registered from the lookup state. pull: the lookup state issues the
//   first registered sample memory read and each pull state registers one
//   result; busy stays high until the next request can be taken.
// reset
//   rst empties every ring at once through per-channel valid bits on the
//   channel table and sets max_pull_burst to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "multi_channel_sample_ring_fifo_unit_assert.svh"

module multi_channel_sample_ring_fifo_unit #(
  parameter int CHANNELS   = mcsrf_pkg::CHANNELS_DEF,
  parameter int RING_DEPTH = mcsrf_pkg::RING_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  opcode,
  input  logic [mcsrf_pkg::CHAN_W-1:0]          channel,
  input  logic signed [mcsrf_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                  burst_last,
  input  logic                                  cfg_wr_en,
  input  logic [mcsrf_pkg::PULL_W-1:0]          cfg_wr_data,
  output logic                                  strobe,
  output logic [1:0]                            status,
  output logic signed [mcsrf_pkg::SAMPLE_W-1:0] sample_out,
  output logic [mcsrf_pkg::CHAN_W-1:0]          out_channel,
  output logic                                  last
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int DEPTH = CHANNELS * RING_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = mcsrf_pkg::PULL_W;
  localparam int CMP_W = (CNT_W > PW) ? CNT_W : PW;

  typedef struct packed {
    logic [PTR_W-1:0] wp;
    logic [PTR_W-1:0] rp;
    logic [CNT_W-1:0] cnt;
    logic             refused;
  } chan_entry_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] ram_addr(input logic [CH_W-1:0] c,
                                             input logic [PTR_W-1:0] p);
    ram_addr = AW'(AW'(c) * AW'(RING_DEPTH) + AW'(p));
  endfunction

  // state and request registers
  mcsrf_pkg::state_t state, state_next;
  logic                           op_q;
  logic [mcsrf_pkg::CHAN_W-1:0]   chan_q;
  logic [CH_W-1:0]                cidx_q;
  logic                           in_range_q;
  logic signed [mcsrf_pkg::SAMPLE_W-1:0] sample_q;
  logic                           blast_q;
  logic [PW-1:0]                  max_pull_burst;

  // channel table memory with valid bits
  chan_entry_t                    tbl_mem [CHANNELS];
  logic [CHANNELS-1:0]            tbl_valid;
  chan_entry_t                    tbl_rd;
  logic                           tbl_vld_q;
  logic                           tbl_we;
  chan_entry_t                    tbl_wdata;
  chan_entry_t                    entry;

  // pull burst tracking
  chan_entry_t                    pend, pend_next;
  logic [PW-1:0]                  remaining, remaining_next;
  logic [PW-1:0]                  lim;
  logic [PW-1:0]                  n;

  // sample memory port
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic signed [mcsrf_pkg::SAMPLE_W-1:0] ram_rdata;

  // result staging
  logic                           res_vld;
  mcsrf_pkg::status_t             res_status;
  mcsrf_pkg::status_t             status_q;
  logic signed [mcsrf_pkg::SAMPLE_W-1:0] res_sample;
  logic                           res_last;

  logic accept;
  logic [CH_W-1:0] chan_idx;

  assign busy     = (state != mcsrf_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign chan_idx = CH_W'(channel);

  // pull limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_pull_burst <= mcsrf_pkg::PULL_BURST_RST;
    end else if (cfg_wr_en) begin
      max_pull_burst <= cfg_wr_data;
    end
  end

  // capture request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= opcode;
      chan_q     <= channel;
      cidx_q     <= chan_idx;
      in_range_q <= (32'(channel) < 32'(CHANNELS));
      sample_q   <= sample_in;
      blast_q    <= burst_last;
    end
  end

  // channel table: read at acceptance, written back at the end of the request;
  // busy keeps the two from meeting on one edge
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[cidx_q] <= tbl_wdata;
    end
    if (accept) begin
      tbl_rd <= tbl_mem[chan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
      tbl_vld_q <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_valid[cidx_q] <= 1'b1;
      end
      if (accept) begin
        tbl_vld_q <= tbl_valid[chan_idx];
      end
    end
  end

  // an entry never written reads as an empty ring
  assign entry = tbl_vld_q ? tbl_rd : '0;

  // clamp the pull limit, then the burst length
  always_comb begin
    if (max_pull_burst == '0) begin
      lim = PW'(1);
    end else if (max_pull_burst > mcsrf_pkg::PULL_LIMIT_CAP) begin
      lim = mcsrf_pkg::PULL_LIMIT_CAP;
    end else begin
      lim = max_pull_burst;
    end
    n = (CMP_W'(entry.cnt) < CMP_W'(lim)) ? PW'(entry.cnt) : lim;
  end

  // next state, memory accesses and result
  always_comb begin
    chan_entry_t upd;
    logic        refuse;
    upd            = entry;
    refuse         = entry.refused || (entry.cnt == CNT_W'(RING_DEPTH));
    state_next     = state;
    pend_next      = pend;
    remaining_next = remaining;
    tbl_we         = 1'b0;
    tbl_wdata      = entry;
    ram_we         = 1'b0;
    ram_waddr      = ram_addr(cidx_q, entry.wp);
    ram_re         = 1'b0;
    ram_raddr      = ram_addr(cidx_q, pend.rp);
    res_vld        = 1'b0;
    res_status     = mcsrf_pkg::ST_PUSH_OK;
    res_sample     = '0;
    res_last       = 1'b1;
    unique case (state)
      mcsrf_pkg::S_IDLE: begin
        if (start) begin
          state_next = mcsrf_pkg::S_LOOKUP;
        end
      end
      mcsrf_pkg::S_LOOKUP: begin
        if (op_q == mcsrf_pkg::OP_PUSH) begin
          res_vld    = 1'b1;
          state_next = mcsrf_pkg::S_IDLE;
          if (!in_range_q) begin
            res_status = mcsrf_pkg::ST_PUSH_FULL;
          end else begin
            if (refuse) begin
              upd.refused = 1'b1;
              res_status  = mcsrf_pkg::ST_PUSH_FULL;
            end else begin
              ram_we  = 1'b1;
              upd.wp  = ring_next(entry.wp);
              upd.cnt = CNT_W'(entry.cnt + 1'b1);
            end
            if (blast_q) begin
              upd.refused = 1'b0;
            end
            tbl_we    = 1'b1;
            tbl_wdata = upd;
          end
        end else if (!in_range_q || entry.cnt == '0) begin
          res_vld    = 1'b1;
          res_status = mcsrf_pkg::ST_PULL_EMPTY;
          state_next = mcsrf_pkg::S_IDLE;
        end else begin
          // first sample read, pointer and count settled up front
          ram_re         = 1'b1;
          ram_raddr      = ram_addr(cidx_q, entry.rp);
          pend_next      = entry;
          pend_next.rp   = ring_next(entry.rp);
          pend_next.cnt  = CNT_W'(entry.cnt - CNT_W'(n));
          remaining_next = n;
          state_next     = mcsrf_pkg::S_PULL;
        end
      end
      mcsrf_pkg::S_PULL: begin
        res_vld    = 1'b1;
        res_status = mcsrf_pkg::ST_PULL_DATA;
        res_sample = ram_rdata;
        res_last   = (remaining == PW'(1));
        if (remaining == PW'(1)) begin
          tbl_we     = 1'b1;
          tbl_wdata  = pend;
          state_next = mcsrf_pkg::S_IDLE;
        end else begin
          ram_re         = 1'b1;
          pend_next.rp   = ring_next(pend.rp);
          remaining_next = PW'(remaining - PW'(1));
        end
      end
      default: begin
        state_next = mcsrf_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcsrf_pkg::S_IDLE;
      remaining <= '0;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  // sample memory
  mcsrf_sample_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sample_q),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    status_q    <= res_status;
    sample_out  <= res_sample;
    out_channel <= chan_q;
    last        <= res_last;
  end

  assign status = status_q;

  // checks
  logic data_res;
  assign data_res = strobe && (status == mcsrf_pkg::ST_PULL_DATA);

  `MCSRF_ASSERT_NXT(a_accept_busy, accept, busy, "request taken but block not busy")
  `MCSRF_ASSERT_NXT(a_burst_cont, data_res && !last, data_res, "pull burst broken before last")
  `MCSRF_ASSERT_IMP(a_strobe_src, strobe, $past(busy), "result without a request in work")
  `MCSRF_ASSERT_IMP(a_pull_rem, state == mcsrf_pkg::S_PULL, remaining != '0, "pull with none left")

endmodule

### sv/mcsrf_sample_ram.sv
// ----------------------------------------------------------------------------
// mcsrf_sample_ram
// simple dual-port sample memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mcsrf_sample_ram #(
  parameter int DEPTH = mcsrf_pkg::CHANNELS_DEF * mcsrf_pkg::RING_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(DEPTH)-1:0]            waddr,
  input  logic signed [mcsrf_pkg::SAMPLE_W-1:0] wdata,
  input  logic                                re,
  input  logic [$clog2(DEPTH)-1:0]            raddr,
  output logic signed [mcsrf_pkg::SAMPLE_W-1:0] rdata
);

  logic signed [mcsrf_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### verif/mcsrf_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsrf_tb_pkg
// mirror of the per-channel sample rings used by the ring fifo testbench.
// every accepted request updates the mirrored rings and queues the results
// it must cause; results from the block are checked in order against them.
// ----------------------------------------------------------------------------
package mcsrf_tb_pkg;
  import mcsrf_pkg::*;

  localparam int NCHAN = CHANNELS_DEF;
  localparam int DEPTH = RING_DEPTH_DEF;

  typedef struct {
    status_t                    status;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          chan;
    logic                       last;
  } ring_result_t;

  class channel_ring_mirror;
    logic signed [SAMPLE_W-1:0] ring_data [NCHAN][DEPTH];
    int unsigned                wr_ptr [NCHAN];
    int unsigned                rd_ptr [NCHAN];
    int unsigned                fill [NCHAN];
    bit                         refusing [NCHAN];
    int unsigned                pull_limit;
    ring_result_t               due_results [$];
    int                         bad_results;

    function new();
      foreach (fill[c]) begin
        wr_ptr[c]   = 0;
        rd_ptr[c]   = 0;
        fill[c]     = 0;
        refusing[c] = 1'b0;
      end
      pull_limit  = 32'(PULL_BURST_RST);
      bad_results = 0;
    endfunction

    // zero acts as one, anything above the cap acts as the cap
    function void set_pull_limit(logic [PULL_W-1:0] value);
      if (value == 0) begin
        pull_limit = 1;
      end else if (value > PULL_LIMIT_CAP) begin
        pull_limit = 32'(PULL_LIMIT_CAP);
      end else begin
        pull_limit = 32'(value);
      end
    endfunction

    // apply one accepted request and queue the results it causes
    function void note_request(opcode_t op, logic [CHAN_W-1:0] ch,
                               logic signed [SAMPLE_W-1:0] smp, logic blast);
      ring_result_t r;
      int unsigned  n;
      int unsigned  k;
      r.status = ST_PUSH_OK;
      r.sample = '0;
      r.chan   = ch;
      r.last   = 1'b1;
      if (op == OP_PUSH) begin
        // a full ring refuses the rest of the burst
        if (refusing[ch] || fill[ch] == DEPTH) begin
          refusing[ch] = 1'b1;
          r.status     = ST_PUSH_FULL;
        end else begin
          ring_data[ch][wr_ptr[ch]] = smp;
          wr_ptr[ch] = (wr_ptr[ch] + 1) % DEPTH;
          fill[ch]++;
        end
        if (blast) refusing[ch] = 1'b0;
        due_results.push_back(r);
      end else if (fill[ch] == 0) begin
        r.status = ST_PULL_EMPTY;
        due_results.push_back(r);
      end else begin
        // drain oldest first, mark the final one
        n = (fill[ch] < pull_limit) ? fill[ch] : pull_limit;
        for (k = 0; k < n; k++) begin
          r.status = ST_PULL_DATA;
          r.sample = ring_data[ch][rd_ptr[ch]];
          r.last   = (k + 1 == n);
          due_results.push_back(r);
          rd_ptr[ch] = (rd_ptr[ch] + 1) % DEPTH;
        end
        fill[ch] -= n;
      end
    endfunction

    // compare one strobed result with the oldest one due
    function void check_result(logic [1:0] st, logic signed [SAMPLE_W-1:0] smp,
                               logic [CHAN_W-1:0] ch, logic lst);
      ring_result_t e;
      if (due_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: status %0d sample %0d channel %0d last %0b",
                   st, smp, ch, lst);
        return;
      end
      e = due_results.pop_front();
      if (st !== e.status || smp !== e.sample || ch !== e.chan || lst !== e.last) begin
        bad_results++;
        if (bad_results <= 10)
          $display("mismatch: expected status %0d sample %0d channel %0d last %0b,",
                   e.status, e.sample, e.chan, e.last,
                   " got status %0d sample %0d channel %0d last %0b",
                   st, smp, ch, lst);
      end
    endfunction
  endclass

endpackage

### verif/multi_channel_sample_ring_fifo_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_sample_ring_fifo_unit_tb
// drives push and pull requests into the ring fifo with random gaps, covers
// sample extremes, empty pulls and the pull limit clamps, and checks every
// strobed result against the mirrored rings across several pull burst limits.
// ----------------------------------------------------------------------------
module multi_channel_sample_ring_fifo_unit_tb;
  import mcsrf_pkg::*;
  import mcsrf_tb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       opcode;
  logic [CHAN_W-1:0]          channel;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       burst_last;
  logic                       cfg_wr_en;
  logic [PULL_W-1:0]          cfg_wr_data;
  logic                       strobe;
  logic [1:0]                 status;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [CHAN_W-1:0]          out_channel;
  logic                       last;

  channel_ring_mirror rings;
  bit                 idling_on;
  int                 cycle_count = 0;

  multi_channel_sample_ring_fifo_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .channel     (channel),
    .sample_in   (sample_in),
    .burst_last  (burst_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .strobe      (strobe),
    .status      (status),
    .sample_out  (sample_out),
    .out_channel (out_channel),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // check every strobed result
  always @(posedge clk) begin
    if (!rst && strobe) rings.check_result(status, sample_out, out_channel, last);
  end

  // hard stop on a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[multi_channel_sample_ring_fifo_unit] ERROR");
      $finish;
    end
  end

  // present one request and hold it until taken; called on a rising edge
  task automatic issue(opcode_t op, logic [CHAN_W-1:0] ch,
                       logic signed [SAMPLE_W-1:0] smp, logic blast);
    start      <= 1'b1;
    opcode     <= op;
    channel    <= ch;
    sample_in  <= smp;
    burst_last <= blast;
    do @(posedge clk); while (busy !== 1'b0);
    rings.note_request(op, ch, smp, blast);
  endtask

  // random gap before a request
  task automatic maybe_idle();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic push(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp,
                      logic blast);
    maybe_idle();
    issue(OP_PUSH, ch, smp, blast);
  endtask

  // sample and burst_last are don't-care on a pull, so they get noise
  task automatic pull(logic [CHAN_W-1:0] ch);
    maybe_idle();
    issue(OP_PULL, ch, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic push_burst(logic [CHAN_W-1:0] ch, int len);
    int i;
    for (i = 0; i < len; i++) push(ch, SAMPLE_W'($urandom), i == len - 1);
  endtask

  // wait until all due results are in and the block is idle
  task automatic settle();
    start <= 1'b0;
    while (rings.due_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_pull_limit(logic [PULL_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rings.set_pull_limit(value);
  endtask

  // mostly well-formed bursts and pulls, some stray pushes
  task automatic random_phase(int count);
    int                done;
    int                kind;
    int                len;
    logic [CHAN_W-1:0] ch;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 9);
      ch   = CHAN_W'($urandom);
      if (kind < 5) begin
        len = $urandom_range(1, 10);
        push_burst(ch, len);
        done += len;
      end else if (kind < 8) begin
        pull(ch);
        done++;
      end else if (kind == 8) begin
        push(ch, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
        done++;
      end else begin
        push(ch, $urandom_range(0, 1) ? 16'h7fff : 16'h8000, 1'b1);
        done++;
      end
    end
  endtask

  initial begin
    rings       = new();
    idling_on   = 1'b1;
    rst         <= 1'b1;
    start       <= 1'b0;
    opcode      <= OP_PUSH;
    channel     <= '0;
    sample_in   <= '0;
    burst_last  <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: sample extremes, empty pulls, single-sample burst
    push(3'd0, 16'h7fff, 1'b0);
    push(3'd0, 16'h8000, 1'b0);
    push(3'd0, 16'h0000, 1'b0);
    push(3'd0, 16'hffff, 1'b1);
    push(3'd7, 16'h5555, 1'b0);
    push(3'd7, 16'haaaa, 1'b1);
    pull(3'd0);
    pull(3'd0);
    pull(3'd3);
    pull(3'd7);
    push(3'd2, 16'h1234, 1'b1);
    pull(3'd2);
    push_burst(3'd4, 5);

    // limit zero behaves as one, oversize limit is capped
    write_pull_limit(7'd0);
    pull(3'd4);
    pull(3'd4);
    write_pull_limit(7'd127);
    pull(3'd4);

    // random traffic under several limits, last stretch back to back
    write_pull_limit(7'd1);
    random_phase(100);
    write_pull_limit(7'd64);
    random_phase(100);
    write_pull_limit(PULL_W'($urandom_range(2, 63)));
    random_phase(100);
    write_pull_limit(PULL_W'($urandom_range(65, 127)));
    idling_on = 1'b0;
    random_phase(90);

    settle();
    repeat (10) @(posedge clk);
    if (rings.bad_results == 0 && rings.due_results.size() == 0) begin
      $display("[multi_channel_sample_ring_fifo_unit] OK");
    end else begin
      $display("[multi_channel_sample_ring_fifo_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/mcsrf_pkg.sv
sv/mcsrf_sample_ram.sv
sv/multi_channel_sample_ring_fifo_unit.sv
verif/mcsrf_tb_pkg.sv
verif/multi_channel_sample_ring_fifo_unit_tb.sv
